>>> hdl/rau_pkg.sv
package rau_pkg;

    localparam int NUM_WIDTH = 32;
    localparam int PROD_WIDTH = 2 * NUM_WIDTH;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 2);

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_NEG = 3'd4;
    localparam logic [2:0] FUNC_CMP = 3'd5;
    localparam logic [2:0] FUNC_RED = 3'd6;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic form;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } rau_cmd_t;

    typedef struct packed {
        logic early_done;
        logic gcd_done;
        logic div_done;
    } rau_status_t;

endpackage

>>> hdl/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rau_status_t status,
    output rau_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GINIT, S_GCD, S_DINIT, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = S_GINIT;
            end
            S_GINIT:
            begin
                if (status.early_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/rau_datapath.sv
module rau_datapath
    import rau_pkg::*;
(
    input  logic                        clk,
    input  rau_cmd_t                    cmd,
    output rau_status_t                 status,
    input  logic [2:0]                  func,
    input  logic signed [NUM_WIDTH-1:0] a_num,
    input  logic signed [NUM_WIDTH-1:0] a_den,
    input  logic signed [NUM_WIDTH-1:0] b_num,
    input  logic signed [NUM_WIDTH-1:0] b_den,
    output logic signed [NUM_WIDTH-1:0] res_num,
    output logic signed [NUM_WIDTH-1:0] res_den,
    output logic                        is_less,
    output logic                        is_equal,
    output logic                        is_greater,
    output logic [1:0]                  error_code
);

    localparam int PW = PROD_WIDTH + 1;

    logic [2:0]                  func_reg;
    logic signed [NUM_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]        p_reg, q_reg, p_next, q_next;
    logic [1:0]                  err_reg;
    logic                        early_reg;
    logic                        neg_reg;
    logic [PW-1:0]               un_reg, ud_reg;
    logic [PW-1:0]               gx_reg, gy_reg;
    logic [CNT_WIDTH-1:0]        shift_reg;
    logic [PW-1:0]               g_reg;
    logic [PW-1:0]               quo_reg, rem_reg;
    logic [PW-1:0]               qd_reg, rd_reg;
    logic [6:0]                  dcnt_reg;
    logic signed [NUM_WIDTH-1:0] rn_reg, rdn_reg;
    logic                        lt_reg, eq_reg, gt_reg;
    logic [1:0]                  eout_reg;

    logic signed [PW-1:0] max_v, min_v;
    assign max_v = (PW)'((65'sd1 <<< (NUM_WIDTH - 1)) - 65'sd1);
    assign min_v = -max_v - (PW)'(1);

    function automatic logic fits(input logic signed [PW-1:0] v, input logic signed [PW-1:0] lo,
                                  input logic signed [PW-1:0] hi);
        fits = (v >= lo) && (v <= hi);
    endfunction

    // First multiplier cycle forms the numerator-side product, second the other.
    always_comb
    begin
        p_next = p_reg;
        q_next = q_reg;
        if (cmd.mul1)
        begin
            unique case (func_reg)
                FUNC_MUL: p_next = PW'(an_reg * bn_reg);
                default:  p_next = PW'(an_reg * bd_reg);
            endcase
        end
        if (cmd.mul2)
        begin
            unique case (func_reg)
                FUNC_MUL: q_next = PW'(ad_reg * bd_reg);
                default:  q_next = PW'(ad_reg * bn_reg);
            endcase
        end
    end

    logic [PW-1:0] gx_sub, gy_sub;
    assign gx_sub = gx_reg - gy_reg;
    assign gy_sub = gy_reg - gx_reg;

    logic [PW:0] rem_sh;
    logic [PW:0] rem_try;
    assign rem_sh  = {rem_reg, quo_reg[PW-1]};
    assign rem_try = rem_sh - {1'b0, g_reg};
    logic [PW:0] rd_sh;
    logic [PW:0] rd_try;
    assign rd_sh  = {rd_reg, qd_reg[PW-1]};
    assign rd_try = rd_sh - {1'b0, g_reg};

    assign status.early_done = early_reg;
    assign status.gcd_done   = (gy_reg == '0);
    assign status.div_done   = (dcnt_reg == 7'(PW));

    logic signed [PW-1:0] sum_v, fin_n;
    logic signed [PW-1:0] neg_a;
    always_comb
    begin
        sum_v = p_reg - q_reg;
        if (func_reg == FUNC_ADD)
        begin
            sum_v = p_reg + q_reg;
        end
        neg_a = -PW'(an_reg);
        fin_n = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        if (cmd.load)
        begin
            func_reg <= func;
            an_reg   <= a_num;
            ad_reg   <= a_den;
            bn_reg   <= b_num;
            bd_reg   <= b_den;
        end
        if (cmd.form)
        begin
            err_reg   <= ERR_OK;
            early_reg <= 1'b1;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            rn_reg    <= '0;
            rdn_reg   <= '0;
            if (func_reg == 3'd7)
            begin
                err_reg <= ERR_OK;
            end
            else if (ad_reg == '0
                || (func_reg != FUNC_NEG && func_reg != FUNC_RED && bd_reg == '0)
                || (func_reg == FUNC_DIV && bn_reg == '0))
            begin
                err_reg <= ERR_ZERO;
            end
            else if (func_reg == FUNC_NEG)
            begin
                if (!fits(neg_a, min_v, max_v))
                begin
                    err_reg <= ERR_RANGE;
                end
                else
                begin
                    rn_reg  <= NUM_WIDTH'(neg_a);
                    rdn_reg <= ad_reg;
                end
            end
            else if (func_reg == FUNC_CMP)
            begin
                if ((ad_reg[NUM_WIDTH-1] != bd_reg[NUM_WIDTH-1]))
                begin
                    lt_reg <= p_reg > q_reg;
                    gt_reg <= p_reg < q_reg;
                end
                else
                begin
                    lt_reg <= p_reg < q_reg;
                    gt_reg <= p_reg > q_reg;
                end
                eq_reg <= p_reg == q_reg;
            end
            else
            begin
                logic signed [PW-1:0] nv, dv;
                nv = sum_v;
                dv = q_reg;
                if (func_reg == FUNC_MUL || func_reg == FUNC_DIV)
                begin
                    nv = p_reg;
                end
                else if (func_reg == FUNC_RED)
                begin
                    nv = PW'(an_reg);
                    dv = PW'(ad_reg);
                end
                else
                begin
                    dv = PW'(ad_reg * bd_reg);
                end
                if (func_reg == FUNC_DIV)
                begin
                    dv = q_reg;
                end
                if (!fits(nv, min_v, max_v) || !fits(dv, min_v, max_v))
                begin
                    err_reg <= ERR_RANGE;
                end
                else if (nv == '0)
                begin
                    rn_reg  <= '0;
                    rdn_reg <= NUM_WIDTH'(1);
                end
                else
                begin
                    early_reg <= 1'b0;
                    neg_reg   <= nv[PW-1] != dv[PW-1];
                    un_reg    <= nv[PW-1] ? PW'(-nv) : nv;
                    ud_reg    <= dv[PW-1] ? PW'(-dv) : dv;
                end
            end
        end
        if (cmd.gcd_init)
        begin
            gx_reg    <= un_reg;
            gy_reg    <= ud_reg;
            shift_reg <= '0;
        end
        // Binary gcd step: strip common factors of two, halve an even value,
        // or replace the larger of two odd values by their halved difference.
        if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg    <= gx_reg >> 1;
                gy_reg    <= gy_reg >> 1;
                shift_reg <= shift_reg + CNT_WIDTH'(1);
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gy_reg;
                gy_reg <= gx_sub >> 1;
            end
            else
            begin
                gy_reg <= gy_sub >> 1;
            end
        end
        if (cmd.div_init)
        begin
            g_reg    <= gx_reg << shift_reg;
            quo_reg  <= un_reg;
            rem_reg  <= '0;
            qd_reg   <= ud_reg;
            rd_reg   <= '0;
            dcnt_reg <= '0;
        end
        // Restoring division of both magnitudes by the gcd, one bit a cycle.
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 7'd1;
            if (!rem_try[PW])
            begin
                rem_reg <= rem_try[PW-1:0];
                quo_reg <= {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[PW-1:0];
                quo_reg <= {quo_reg[PW-2:0], 1'b0};
            end
            if (!rd_try[PW])
            begin
                rd_reg <= rd_try[PW-1:0];
                qd_reg <= {qd_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= rd_sh[PW-1:0];
                qd_reg <= {qd_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            if (err_reg != ERR_OK)
            begin
                rn_reg   <= '0;
                rdn_reg  <= '0;
                lt_reg   <= 1'b0;
                eq_reg   <= 1'b0;
                gt_reg   <= 1'b0;
                eout_reg <= err_reg;
            end
            else if (!early_reg)
            begin
                if (!fits(fin_n, min_v, max_v) || !fits($signed(qd_reg), min_v, max_v))
                begin
                    rn_reg   <= '0;
                    rdn_reg  <= '0;
                    eout_reg <= ERR_RANGE;
                end
                else
                begin
                    rn_reg   <= NUM_WIDTH'(fin_n);
                    rdn_reg  <= NUM_WIDTH'(qd_reg);
                    eout_reg <= ERR_OK;
                end
            end
            else
            begin
                eout_reg <= ERR_OK;
            end
        end
    end

    assign res_num    = rn_reg;
    assign res_den    = rdn_reg;
    assign is_less    = lt_reg;
    assign is_equal   = eq_reg;
    assign is_greater = gt_reg;
    assign error_code = eout_reg;

endmodule

>>> hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: one item at a time, result registered until taken.
// States from input beat to result beat: IDLE (load), MUL1, MUL2, FORM, GINIT, then
// FIN for negate, compare, errors, zero numerators and the unused opcode; otherwise
// the binary gcd loop (GCD), DINIT and the bit-serial divider (DIV) come before FIN.
// A new item is accepted only after the previous result beat has been taken.
// Reset (rst_n, asynchronous, active low) empties the controller and output beat.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic signed [NUM_WIDTH-1:0] a_num,
    input  logic signed [NUM_WIDTH-1:0] a_den,
    input  logic signed [NUM_WIDTH-1:0] b_num,
    input  logic signed [NUM_WIDTH-1:0] b_den,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [NUM_WIDTH-1:0] res_num,
    output logic signed [NUM_WIDTH-1:0] res_den,
    output logic                        is_less,
    output logic                        is_equal,
    output logic                        is_greater,
    output logic [1:0]                  error_code
);

    rau_cmd_t    cmd;
    rau_status_t status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rau_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .func       (func),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .res_num    (res_num),
        .res_den    (res_den),
        .is_less    (is_less),
        .is_equal   (is_equal),
        .is_greater (is_greater),
        .error_code (error_code)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    localparam int  RANDOM_OPS  = 400;
    localparam int  MAX_GAP     = 15;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [2:0]                  func;
        logic signed [NUM_WIDTH-1:0] a_num;
        logic signed [NUM_WIDTH-1:0] a_den;
        logic signed [NUM_WIDTH-1:0] b_num;
        logic signed [NUM_WIDTH-1:0] b_den;
    } frac_op_t;

    typedef struct {
        logic signed [NUM_WIDTH-1:0] res_num;
        logic signed [NUM_WIDTH-1:0] res_den;
        logic                        is_less;
        logic                        is_equal;
        logic                        is_greater;
        logic [1:0]                  error_code;
    } frac_answer_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [2:0]                  func;
    logic signed [NUM_WIDTH-1:0] a_num;
    logic signed [NUM_WIDTH-1:0] a_den;
    logic signed [NUM_WIDTH-1:0] b_num;
    logic signed [NUM_WIDTH-1:0] b_den;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [NUM_WIDTH-1:0] res_num;
    logic signed [NUM_WIDTH-1:0] res_den;
    logic                        is_less;
    logic                        is_equal;
    logic                        is_greater;
    logic [1:0]                  error_code;

    frac_op_t     pending_ops[$];
    frac_answer_t awaited_answers[$];
    int           fail_count;
    int           ops_accepted;
    int           answers_checked;
    int           total_ops;
    longint       cycle_count;
    bit           in_fire;
    bit           out_fire;
    int           send_gap;
    int           stall_left;

    rational_arithmetic_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_num    (res_num),
        .res_den    (res_den),
        .is_less    (is_less),
        .is_equal   (is_equal),
        .is_greater (is_greater),
        .error_code (error_code)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic bit fits_word(longint v);
        longint top;
        top = (longint'(1) << (NUM_WIDTH - 1)) - 1;
        return (v >= -top - 1) && (v <= top);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Brings n/d to lowest terms with a positive denominator; flags a result
    // that no longer fits the word.
    function automatic logic [1:0] lowest_terms(longint n, longint d,
                                                output longint rn, output longint rd);
        longint un;
        longint ud;
        longint x;
        longint y;
        longint t;
        bit     neg;
        un = magnitude(n);
        ud = magnitude(d);
        neg = (n < 0) != (d < 0);
        if (un == 0)
        begin
            rn = 0;
            rd = 1;
            return ERR_OK;
        end
        x = un;
        y = ud;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        un = un / x;
        ud = ud / x;
        rn = neg ? -un : un;
        rd = ud;
        if (!fits_word(rn) || !fits_word(rd))
            return ERR_RANGE;
        return ERR_OK;
    endfunction

    function automatic frac_answer_t compute_answer(frac_op_t op);
        frac_answer_t ans;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint n;
        longint d;
        longint rn;
        longint rd;
        longint p;
        longint q;
        logic [1:0] err;
        bit lt;
        bit eq;
        bit gt;
        bit t;
        an = op.a_num;
        ad = op.a_den;
        bn = op.b_num;
        bd = op.b_den;
        n = 0;
        d = 1;
        rn = 0;
        rd = 0;
        lt = 0;
        eq = 0;
        gt = 0;
        err = ERR_OK;
        if (op.func <= FUNC_CMP)
        begin
            if (ad == 0 || (op.func != FUNC_NEG && bd == 0) || (op.func == FUNC_DIV && bn == 0))
                err = ERR_ZERO;
        end
        else if (op.func == FUNC_RED && ad == 0)
            err = ERR_ZERO;

        if (err == ERR_OK)
        begin
            case (op.func)
                FUNC_ADD:
                begin
                    n = an * bd + ad * bn;
                    d = ad * bd;
                end
                FUNC_SUB:
                begin
                    n = an * bd - ad * bn;
                    d = ad * bd;
                end
                FUNC_MUL:
                begin
                    n = an * bn;
                    d = ad * bd;
                end
                FUNC_DIV:
                begin
                    n = an * bd;
                    d = ad * bn;
                end
                FUNC_NEG:
                begin
                    rn = -an;
                    rd = ad;
                    if (!fits_word(rn))
                        err = ERR_RANGE;
                end
                FUNC_CMP:
                begin
                    p = an * bd;
                    q = bn * ad;
                    lt = p < q;
                    gt = p > q;
                    eq = p == q;
                    // The order is reversed when exactly one denominator is negative.
                    if ((ad < 0) != (bd < 0))
                    begin
                        t = lt;
                        lt = gt;
                        gt = t;
                    end
                end
                FUNC_RED:
                begin
                    n = an;
                    d = ad;
                end
                default:
                begin
                end
            endcase
            if (op.func <= FUNC_DIV || op.func == FUNC_RED)
            begin
                if (!fits_word(n) || !fits_word(d))
                    err = ERR_RANGE;
                else
                    err = lowest_terms(n, d, rn, rd);
            end
        end

        if (err != ERR_OK)
        begin
            rn = 0;
            rd = 0;
            lt = 0;
            eq = 0;
            gt = 0;
        end
        ans.res_num    = rn[NUM_WIDTH-1:0];
        ans.res_den    = rd[NUM_WIDTH-1:0];
        ans.is_less    = lt;
        ans.is_equal   = eq;
        ans.is_greater = gt;
        ans.error_code = err;
        return ans;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        $display("mismatch on answer %0d: %s got %0d, wanted %0d",
                 answers_checked, what, got, want);
    endtask

    function automatic logic signed [NUM_WIDTH-1:0] pick_value();
        logic signed [NUM_WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $signed($urandom_range(0, 200)) - 100;
            2:    v = $urandom;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: v = {1'b1, {(NUM_WIDTH-1){1'b0}}};
                    1: v = {1'b0, {(NUM_WIDTH-1){1'b1}}};
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            4:    v = $signed(32'(1) << $urandom_range(0, 30)) * ($urandom_range(0, 1) ? 1 : -1);
            default: v = $signed($urandom_range(0, 131070)) - 65535;
        endcase
        return v;
    endfunction

    task automatic queue_op(logic [2:0] f, logic signed [NUM_WIDTH-1:0] an,
                            logic signed [NUM_WIDTH-1:0] ad, logic signed [NUM_WIDTH-1:0] bn,
                            logic signed [NUM_WIDTH-1:0] bd);
        frac_op_t op;
        op.func = f;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        pending_ops.push_back(op);
    endtask

    // Input driver: beats change on the falling edge only.
    always @(negedge clk)
    begin
        logic next_valid;
        frac_op_t op;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_fire)
            begin
                next_valid = 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops.pop_front();
                    func  <= op.func;
                    a_num <= op.a_num;
                    a_den <= op.a_den;
                    b_num <= op.b_num;
                    b_den <= op.b_den;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;

            if (out_fire)
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: samples both channels on the rising edge.
    always @(posedge clk)
    begin
        frac_op_t op;
        frac_answer_t want;
        in_fire  = 0;
        out_fire = 0;
        if (rst_n)
        begin
            cycle_count++;
            if (in_valid && in_ready)
            begin
                in_fire = 1;
                op.func = func;
                op.a_num = a_num;
                op.a_den = a_den;
                op.b_num = b_num;
                op.b_den = b_den;
                awaited_answers.push_back(compute_answer(op));
                ops_accepted++;
            end
            if (out_valid && out_ready)
            begin
                out_fire = 1;
                if (awaited_answers.size() == 0)
                begin
                    fail_count++;
                    $display("answer beat arrived with nothing outstanding");
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (res_num !== want.res_num)
                        report_mismatch("res_num", res_num, want.res_num);
                    if (res_den !== want.res_den)
                        report_mismatch("res_den", res_den, want.res_den);
                    if (is_less !== want.is_less)
                        report_mismatch("is_less", is_less, want.is_less);
                    if (is_equal !== want.is_equal)
                        report_mismatch("is_equal", is_equal, want.is_equal);
                    if (is_greater !== want.is_greater)
                        report_mismatch("is_greater", is_greater, want.is_greater);
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", error_code, want.error_code);
                end
                answers_checked++;
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timed out after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [NUM_WIDTH-1:0] smin;
        logic signed [NUM_WIDTH-1:0] smax;
        logic [2:0] f;
        logic signed [NUM_WIDTH-1:0] ad;
        logic signed [NUM_WIDTH-1:0] bd;
        smin = {1'b1, {(NUM_WIDTH-1){1'b0}}};
        smax = {1'b0, {(NUM_WIDTH-1){1'b1}}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = '0;
        a_num = '0;
        a_den = '0;
        b_num = '0;
        b_den = '0;
        fail_count = 0;
        ops_accepted = 0;
        answers_checked = 0;
        cycle_count = 0;
        send_gap = 0;
        stall_left = 0;

        // Directed cases: every operation, zero denominators, divide by zero,
        // overflow of products, negation of the most negative value, negative
        // denominators in compare, zero numerators and the unused opcode.
        queue_op(FUNC_ADD, 1, 2, 1, 3);
        queue_op(FUNC_SUB, 1, 2, 1, 2);
        queue_op(FUNC_MUL, -6, 4, 2, -9);
        queue_op(FUNC_DIV, 3, 4, -9, 8);
        queue_op(FUNC_NEG, 5, -7, 0, 0);
        queue_op(FUNC_NEG, smin, 1, 0, 0);
        queue_op(FUNC_NEG, smax, smin, 0, 0);
        queue_op(FUNC_CMP, 1, 2, 2, 3);
        queue_op(FUNC_CMP, 1, -2, 2, 3);
        queue_op(FUNC_CMP, 4, 8, -1, -2);
        queue_op(FUNC_RED, 12, -18, 0, 0);
        queue_op(FUNC_RED, 0, -5, 0, 0);
        queue_op(FUNC_RED, 5, smin, 0, 0);
        queue_op(FUNC_RED, smin, smin, 0, 0);
        queue_op(FUNC_ADD, 1, 0, 1, 1);
        queue_op(FUNC_SUB, 1, 1, 1, 0);
        queue_op(FUNC_DIV, 1, 1, 0, 5);
        queue_op(FUNC_CMP, 1, 0, 1, 1);
        queue_op(FUNC_MUL, smax, 1, smax, 1);
        queue_op(FUNC_ADD, smax, 1, smax, 1);
        queue_op(FUNC_MUL, smin, 1, -1, 1);
        queue_op(FUNC_DIV, smax, smin, smin, smax);
        queue_op(3'd7, smin, 0, smax, 0);
        queue_op(FUNC_MUL, 0, smax, smax, smin);
        queue_op(FUNC_SUB, smin, -1, 0, 3);

        repeat (RANDOM_OPS)
        begin
            f = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            ad = pick_value();
            bd = pick_value();
            // Keep denominators mostly nonzero so most beats reach the arithmetic.
            if (ad == 0 && $urandom_range(0, 3) != 0)
                ad = $signed($urandom_range(1, 50));
            if (bd == 0 && $urandom_range(0, 3) != 0)
                bd = -$signed($urandom_range(1, 50));
            queue_op(f, pick_value(), ad, pick_value(), bd);
        end
        total_ops = pending_ops.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (ops_accepted == total_ops && awaited_answers.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (awaited_answers.size() != 0)
        begin
            fail_count++;
            $display("%0d answers never arrived", awaited_answers.size());
        end

        $display("Ran %0d fraction operations over all opcodes, %0d answers compared,",
                 ops_accepted, answers_checked);
        $display("with random gaps on both channels, in %0d cycles.", cycle_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
